[hw/rtl/bdq_pkg.sv]
// Package for the bounded deque with duplicate removal.
// Holds sizes, command and status codes; used by the top level, the checkers and the testbench.
package bdq_pkg;
    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WW    = 32;

    typedef enum logic [3:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_DEDUP      = 4'd4,
        CMD_READ_AT    = 4'd5,
        CMD_FIRST      = 4'd6,
        CMD_LAST       = 4'd7,
        CMD_SUCC       = 4'd8,
        CMD_PRED       = 4'd9
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;
endpackage

[hw/rtl/bdq_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hw/rtl/bounded_deque_with_dedup.sv]
// Channel | dir | tdata fields (low bit up)               | tuser
// s_axis  | in  | command[3:0] value[35:4] position[44:36] | -
// m_axis  | out | status[1:0] word[33:2] dups[34] occ[43:35] | -
// Push, failed commands, dedup on fewer than two entries and unused codes go from accept
// straight to S_OUT; pop and reads first pass S_READ (one registered RAM read), then S_OUT.
// Dedup walks pairs through the single RAM port in states S_DI, S_DJ, S_DCMP and S_DWR.
// Reset (synchronous, active low) empties the ring; store contents are kept.
// A result waits in the output register; the next word is taken the cycle after it goes,
// so a new word is only taken once the result of the last one has been taken.
// Top level of the bounded deque; uses bdq_pkg and bdq_ram.
module bounded_deque_with_dedup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command, value, position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, word, dups_removed, occupancy
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_OUT, S_DI, S_DJ, S_DCMP, S_DWR} t_state;

    localparam int AW = bdq_pkg::AW;
    localparam int CW = bdq_pkg::CW;
    localparam int WW = bdq_pkg::WW;

    t_state          r_state;
    logic [AW-1:0]   r_front;
    logic [CW-1:0]   r_count;
    logic [3:0]      r_cmd;
    logic [CW-1:0]   r_i, r_j, r_kept;
    logic [WW-1:0]   r_w;
    logic            r_ovalid;
    logic [1:0]      r_ostatus;
    logic [WW-1:0]   r_oword;
    logic            r_odups;

    logic            we;
    logic [AW-1:0]   addr;
    logic [WW-1:0]   wdata, rdata;

    logic [3:0]      in_cmd;
    logic [WW-1:0]   in_val;
    logic [CW-1:0]   in_pos;
    logic [CW-1:0]   succ_k, pred_k;

    assign in_cmd = s_axis_tdata[3:0];
    assign in_val = s_axis_tdata[35:4];
    assign in_pos = s_axis_tdata[44:36];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_count, r_odups, r_oword, r_ostatus};

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {1'b0, {(CW-AW){1'b0}}, f} + {1'b0, k};
        return s[AW-1:0];
    endfunction

    // successor offset = pos mod n, predecessor = (pos-2+n) mod n, pos in 1..n
    assign succ_k = (in_pos == r_count) ? '0 : in_pos;
    assign pred_k = (in_pos == CW'(1)) ? r_count - CW'(1) : in_pos - CW'(2);

    bdq_ram #(.WIDTH(WW), .DEPTH(bdq_pkg::DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    logic acc;
    logic full, empty, bad_pos;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign full  = (r_count == CW'(bdq_pkg::DEPTH));
    assign empty = (r_count == '0);
    assign bad_pos = (in_pos == '0) || (in_pos > r_count);

    always_comb begin
        we    = 1'b0;
        addr  = r_front;
        wdata = in_val;
        unique case (r_state)
            S_IDLE: begin
                unique case (in_cmd)
                    bdq_pkg::CMD_PUSH_FRONT: begin
                        addr = r_front - AW'(1);
                        we = acc && !full;
                    end
                    bdq_pkg::CMD_PUSH_BACK: begin
                        addr = slot(r_front, r_count);
                        we = acc && !full;
                    end
                    bdq_pkg::CMD_POP_BACK,
                    bdq_pkg::CMD_LAST:    addr = slot(r_front, r_count - CW'(1));
                    bdq_pkg::CMD_READ_AT: addr = slot(r_front, in_pos - CW'(1));
                    bdq_pkg::CMD_SUCC:    addr = slot(r_front, succ_k);
                    bdq_pkg::CMD_PRED:    addr = slot(r_front, pred_k);
                    default:              addr = r_front;
                endcase
            end
            S_DI:   addr = slot(r_front, r_i);
            S_DJ:   addr = slot(r_front, r_j);
            S_DWR: begin
                addr  = slot(r_front, r_kept);
                wdata = r_w;
                we    = 1'b1;
            end
            default: addr = r_front;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_cmd     <= in_cmd;
                        r_ostatus <= bdq_pkg::ST_OK;
                        r_oword   <= '0;
                        r_odups   <= 1'b0;
                        r_state   <= S_OUT;
                        unique case (in_cmd)
                            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                                if (full) begin
                                    r_ostatus <= bdq_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    if (in_cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                                        r_front <= r_front - AW'(1);
                                    end
                                end
                            end
                            bdq_pkg::CMD_DEDUP: begin
                                r_i <= '0;
                                r_kept <= '0;
                                r_state <= (r_count < CW'(2)) ? S_OUT : S_DI;
                            end
                            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK,
                            bdq_pkg::CMD_FIRST, bdq_pkg::CMD_LAST: begin
                                if (empty) r_ostatus <= bdq_pkg::ST_EMPTY;
                                else r_state <= S_READ;
                            end
                            bdq_pkg::CMD_READ_AT, bdq_pkg::CMD_SUCC, bdq_pkg::CMD_PRED: begin
                                if (empty) r_ostatus <= bdq_pkg::ST_EMPTY;
                                else if (bad_pos) r_ostatus <= bdq_pkg::ST_RANGE;
                                else r_state <= S_READ;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_READ: begin
                    r_oword <= rdata;
                    if (r_cmd == bdq_pkg::CMD_POP_FRONT) begin
                        r_front <= r_front + AW'(1);
                        r_count <= r_count - CW'(1);
                    end else if (r_cmd == bdq_pkg::CMD_POP_BACK) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_DI: begin
                    // word i appears on rdata next cycle; compare against kept 0..
                    r_j <= '0;
                    r_state <= S_DJ;
                    if (r_i == r_count) begin
                        if (r_kept != r_count) begin
                            r_count <= r_kept;
                            r_odups <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_DJ: begin
                    if (r_j == '0) r_w <= rdata;
                    if (r_j == r_kept) begin
                        r_state <= S_DWR;
                    end else begin
                        r_state <= S_DCMP;
                    end
                end
                S_DCMP: begin
                    // rdata holds kept entry j
                    if (rdata == r_w) begin
                        r_i <= r_i + CW'(1);
                        r_state <= S_DI;
                    end else begin
                        r_j <= r_j + CW'(1);
                        r_state <= S_DJ;
                    end
                end
                S_DWR: begin
                    r_kept <= r_kept + CW'(1);
                    r_i <= r_i + CW'(1);
                    r_state <= S_DI;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/bdq_checker.sv]
// Port-level checks for the bounded deque.
// Bound to bounded_deque_with_dedup; uses bdq_pkg.
module bdq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // occupancy never exceeds the ring size
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[43:35] <= 9'(bdq_pkg::DEPTH))
        else $error("occupancy above depth");
    // failed status carries a zero word
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != bdq_pkg::ST_OK) |-> m_axis_tdata[33:2] == '0)
        else $error("nonzero word on error");
    // no new word taken while a result waits
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with pending result");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
endmodule

bind bounded_deque_with_dedup bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/bounded_deque_with_dedup_chk.sv]
`timescale 1ns / 1ps
// Checker for the bounded deque: watches both stream channels, predicts each result word
// from its own copy of the ring and compares field by field. Depends on bdq_pkg.
module bounded_deque_with_dedup_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_dedups
);
    // highest field first: occupancy sits at the top, status at the bottom
    typedef struct packed {
        logic [bdq_pkg::CW-1:0] occ;
        logic                   dups;
        logic [bdq_pkg::WW-1:0] word;
        logic [1:0]             status;
    } t_result;

    logic [bdq_pkg::WW-1:0] ring [bdq_pkg::DEPTH];
    logic [bdq_pkg::AW-1:0] head;
    int                     fill;
    t_result                expected_q [$];

    function automatic logic [bdq_pkg::WW-1:0] at(int k);
        return ring[(head + k) % bdq_pkg::DEPTH];
    endfunction

    // Apply one command to the model ring and return the result it yields.
    function automatic t_result apply_cmd(bdq_pkg::t_cmd cmd, logic [bdq_pkg::WW-1:0] val,
                                          int pos);
        t_result r;
        int kept;
        bit seen;
        r = '0;
        case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (fill >= bdq_pkg::DEPTH) begin
                    r.status = bdq_pkg::ST_FULL;
                end else if (cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                    head = head - 1'b1;
                    ring[head] = val;
                    fill++;
                end else begin
                    ring[(head + fill) % bdq_pkg::DEPTH] = val;
                    fill++;
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                if (fill == 0) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else if (cmd == bdq_pkg::CMD_POP_FRONT) begin
                    r.word = ring[head];
                    head = head + 1'b1;
                    fill--;
                end else begin
                    r.word = at(fill - 1);
                    fill--;
                end
            end
            bdq_pkg::CMD_DEDUP: begin
                kept = 0;
                for (int i = 0; i < fill; i++) begin
                    seen = 0;
                    for (int j = 0; j < kept; j++)
                        if (at(j) == at(i)) seen = 1;
                    if (!seen) begin
                        ring[(head + kept) % bdq_pkg::DEPTH] = at(i);
                        kept++;
                    end
                end
                if (kept != fill) begin
                    r.dups = 1'b1;
                    fill = kept;
                end
            end
            bdq_pkg::CMD_READ_AT, bdq_pkg::CMD_SUCC, bdq_pkg::CMD_PRED: begin
                if (fill == 0) r.status = bdq_pkg::ST_EMPTY;
                else if (pos < 1 || pos > fill) r.status = bdq_pkg::ST_RANGE;
                else if (cmd == bdq_pkg::CMD_READ_AT) r.word = at(pos - 1);
                else if (cmd == bdq_pkg::CMD_SUCC) r.word = at(pos % fill);
                else r.word = at((pos - 2 + fill) % fill);
            end
            bdq_pkg::CMD_FIRST, bdq_pkg::CMD_LAST: begin
                if (fill == 0) r.status = bdq_pkg::ST_EMPTY;
                else r.word = (cmd == bdq_pkg::CMD_FIRST) ? at(0) : at(fill - 1);
            end
            default: ;
        endcase
        r.occ = fill[bdq_pkg::CW-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            head = '0;
            fill = 0;
            expected_q.delete();
            o_errors <= 0;
            o_pending <= 0;
            o_results <= 0;
            o_dedups <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[43:0];
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result word %h", i_m_tdata);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.word !== want.word) begin
                        $error("word: expected %h actual %h", want.word, got.word);
                        errs++;
                    end
                    if (got.dups !== want.dups) begin
                        $error("dups_removed: expected %0d actual %0d", want.dups, got.dups);
                        errs++;
                    end
                    if (got.occ !== want.occ) begin
                        $error("occupancy: expected %0d actual %0d", want.occ, got.occ);
                        errs++;
                    end
                    if (want.dups) o_dedups <= o_dedups + 1;
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(apply_cmd(bdq_pkg::t_cmd'(i_s_tdata[3:0]),
                                               i_s_tdata[35:4], int'(i_s_tdata[44:36])));
            o_errors <= o_errors + errs;
            o_pending <= expected_q.size();
        end
    end
endmodule

[test/bounded_deque_with_dedup_tb.sv]
`timescale 1ns / 1ps
// Top of the deque testbench: clock, reset, stimulus and verdict.
// Depends on bdq_pkg, bounded_deque_with_dedup and bounded_deque_with_dedup_chk.
module bounded_deque_with_dedup_tb;
    localparam int IDLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // command[3:0] value[35:4] position[44:36]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status[1:0] word[33:2] dups[34] occupancy[43:35]

    int  errors, pending, results, dedups;
    int  sent;
    int  idle_cycles;
    bit  hold_off;
    int  model_fill;  // rough occupancy to shape commands

    bounded_deque_with_dedup i_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    bounded_deque_with_dedup_chk i_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_dedups(dedups)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Offer one word and hold it until taken.
    task automatic send_word(bdq_pkg::t_cmd cmd, logic [31:0] val, logic [8:0] pos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, pos, val, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK:
                if (model_fill < bdq_pkg::DEPTH) model_fill++;
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK:
                if (model_fill > 0) model_fill--;
            default: ;
        endcase
    endtask

    task automatic gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        // Small pool makes duplicates likely; the rest is full-range.
        if ($urandom_range(0, 2) != 0) return $urandom_range(0, 7) - 4;
        return $urandom;
    endfunction

    // Receiver stall pattern plus a long hold-off on request.
    initial begin
        int phase;
        phase = 0;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            phase++;
            if (phase % 64 < 20) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else if (i_rst_n)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int burst;
        int kind;
        bdq_pkg::t_cmd cmd;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        hold_off      = 0;
        sent          = 0;
        model_fill    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-store cases, extremes, wraps, dedup, unused codes.
        send_word(bdq_pkg::CMD_POP_FRONT, 0, 1);
        send_word(bdq_pkg::CMD_POP_BACK, 0, 1);
        send_word(bdq_pkg::CMD_FIRST, 0, 0);
        send_word(bdq_pkg::CMD_LAST, 0, 0);
        send_word(bdq_pkg::CMD_READ_AT, 0, 1);
        send_word(bdq_pkg::CMD_SUCC, 0, 1);
        send_word(bdq_pkg::CMD_PRED, 0, 1);
        send_word(bdq_pkg::CMD_DEDUP, 0, 0);
        send_word(bdq_pkg::CMD_PUSH_BACK, 32'h8000_0000, 0);
        send_word(bdq_pkg::CMD_DEDUP, 0, 0);
        send_word(bdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF, 9'h1FF);
        send_word(bdq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 0);
        send_word(bdq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF, 0);
        send_word(bdq_pkg::CMD_READ_AT, 0, 0);
        send_word(bdq_pkg::CMD_READ_AT, 0, 5);
        send_word(bdq_pkg::CMD_READ_AT, 0, 9'h1FF);
        send_word(bdq_pkg::CMD_SUCC, 0, 4);
        send_word(bdq_pkg::CMD_PRED, 0, 1);
        send_word(bdq_pkg::CMD_FIRST, 0, 0);
        send_word(bdq_pkg::CMD_LAST, 0, 0);
        send_word(bdq_pkg::CMD_DEDUP, 0, 0);
        // dedup drops the repeated 7FFF_FFFF
        model_fill--;
        send_word(bdq_pkg::t_cmd'(4'd10), 32'h1234_5678, 3);
        send_word(bdq_pkg::t_cmd'(4'd15), 0, 0);
        send_word(bdq_pkg::CMD_POP_BACK, 0, 0);
        send_word(bdq_pkg::CMD_POP_FRONT, 0, 0);

        // Fill to full under a long receiver hold-off, push and read on full, then pop back down.
        hold_off = 1;
        while (model_fill < bdq_pkg::DEPTH)
            send_word(bdq_pkg::CMD_PUSH_BACK, $urandom, 9'($urandom));
        send_word(bdq_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5, 0);
        send_word(bdq_pkg::CMD_PUSH_BACK, 32'h5A5A_5A5A, 0);
        send_word(bdq_pkg::CMD_READ_AT, 0, 256);
        send_word(bdq_pkg::CMD_SUCC, 0, 256);
        send_word(bdq_pkg::CMD_PRED, 0, 1);
        while (model_fill > 12)
            send_word($urandom_range(0, 1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK,
                      0, 0);

        // Random part: keep the ring small most of the time so dedup stays short.
        while (sent < 1050) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) cmd = (model_fill < 24) ? bdq_pkg::t_cmd'($urandom_range(0, 1))
                                                       : bdq_pkg::t_cmd'($urandom_range(2, 3));
                else if (kind < 45) cmd = bdq_pkg::t_cmd'($urandom_range(2, 3));
                else if (kind < 50) cmd = bdq_pkg::CMD_DEDUP;
                else if (kind < 97) cmd = bdq_pkg::t_cmd'($urandom_range(5, 9));
                else cmd = bdq_pkg::t_cmd'($urandom_range(10, 15));
                send_word(cmd, ($urandom_range(0, 1) ? rand_val() : $urandom),
                          ($urandom_range(0, 7) == 0) ? 9'($urandom)
                                                      : 9'($urandom_range(0, model_fill + 1)));
            end
            if ($urandom_range(0, 2) != 0) gap();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d command words and %0d results, %0d dedups removing entries,",
                 sent, results, dedups);
        $display("including full and empty stores, position range edges and wraparound reads.");
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
